// File: design/stk_pkg.sv
// Shared types and constants for the message deframer.
// No dependencies; used by every module of the block and by the port checker.
`default_nettype none

package stk_pkg;

    localparam logic [7:0] START_BYTE = 8'h1B;
    localparam logic [7:0] TOKEN_BYTE = 8'h0E;

    typedef enum logic [1:0] {
        KIND_BODY = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] frame_seq;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// File: design/stk_core.sv
// Parser: header collection, body pass-through, checksum closes frame.
// Depends on stk_pkg for the result struct and frame constants.
`default_nettype none

module stk_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic [7:0]       rx_byte,
    output stk_pkg::result_t      res,
    output logic                  res_valid
);

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SEQ    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TOKEN  = 3'd4,
        PH_BODY   = 3'd5,
        PH_SUM    = 3'd6
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        start_ok_reg, start_ok_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] count_reg, count_next;

    always_comb
    begin
        phase_next    = phase_reg;
        start_ok_next = start_ok_reg;
        seq_next      = seq_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res.kind      = stk_pkg::KIND_BODY;
        res.data      = 8'h00;
        res.frame_seq = seq_reg;
        res.last      = 1'b0;
        unique case (phase_reg)
            PH_SEQ:
            begin
                seq_next   = rx_byte;
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                length_next = {length_reg[15:8], rx_byte};
                phase_next  = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                count_next = 16'h0000;
                if (!start_ok_reg || rx_byte != stk_pkg::TOKEN_BYTE)
                begin
                    phase_next = PH_START;
                    res_valid  = 1'b1;
                    res.kind   = stk_pkg::KIND_BAD;
                    res.last   = 1'b1;
                end
                else if (length_reg == 16'h0000)
                begin
                    phase_next = PH_SUM;
                end
                else
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                count_next = count_reg + 16'd1;
                if (count_next >= length_reg)
                begin
                    phase_next = PH_SUM;
                end
                res_valid = 1'b1;
                res.data  = rx_byte;
            end
            PH_SUM:
            begin
                phase_next = PH_START;
                res_valid  = 1'b1;
                res.kind   = stk_pkg::KIND_DONE;
                res.last   = 1'b1;
            end
            default:
            begin
                // start byte, and the unused phase code
                start_ok_next = (rx_byte == stk_pkg::START_BYTE);
                phase_next    = PH_SEQ;
            end
        endcase
        if (!advance)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            start_ok_reg <= 1'b0;
            seq_reg      <= 8'h00;
            length_reg   <= 16'h0000;
            count_reg    <= 16'h0000;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            start_ok_reg <= start_ok_next;
            seq_reg      <= seq_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/stk_out_buf.sv
// Two-entry result buffer between the parser and the output stream.
// Depends on stk_pkg for the result struct.
`default_nettype none

module stk_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire stk_pkg::result_t push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output stk_pkg::result_t      out_data
);

    logic [1:0]        cnt_reg, cnt_next;
    stk_pkg::result_t  head_reg, head_next;
    stk_pkg::result_t  tail_reg, tail_next;
    logic              pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            // advance the tail, or take the new result straight into the head
            if (cnt_reg == 2'd2)
            begin
                head_next = tail_reg;
            end
            else if (push)
            begin
                head_next = push_data;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                head_next = push_data;
            end
            else
            begin
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// File: design/stk500v2_message_deframer.sv
// Top level of the message deframer: input register, parser, result buffer.
// Depends on stk_pkg, stk_core and stk_out_buf.
//
// Usage:
//   s_axis carries received serial bytes, one byte per transaction.
//   m_axis carries results: tuser gives the kind (body byte, frame complete,
//   bad header), tdata the body byte and the frame's sequence number, and
//   tlast marks the result that closes a frame or a discarded header.
//   Good header bytes produce no result; the checksum byte yields frame complete.
// Timing:
//   One byte is accepted per cycle while s_axis_tready is high. A byte
//   taken sits in the input register, is parsed into the result buffer
//   once the buffer has room, and its result leaves from the buffer head.
//   The rate is set by the parser's single state update per byte.
// Reset:
//   rst_n clears the parser to hunt for a header start, and empties the
//   input register and the result buffer.
// Stall:
//   While m_axis_tready is low the buffer holds up to two results; the
//   input register then holds one more byte and s_axis_tready drops.
//   Neither ready depends on the other side's ready in the same cycle.
`default_nettype none

module stk500v2_message_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] data, [15:8] frame_seq
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast
);

    logic              in_vld_reg, in_vld_next;
    logic [7:0]        in_byte_reg;
    logic              buf_full;
    logic              advance;
    logic              s_accept;
    logic              res_valid;
    stk_pkg::result_t  res;
    stk_pkg::result_t  out_res;

    // parse the held byte whenever the buffer has room for its result
    assign advance       = in_vld_reg && !buf_full;
    assign s_axis_tready = !in_vld_reg || !buf_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // hold the byte until it has been parsed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    stk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .rx_byte   (in_byte_reg),
        .res       (res),
        .res_valid (res_valid)
    );

    stk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {out_res.frame_seq, out_res.data};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// File: design/stk_port_checker.sv
// Port-level checks on the deframer's output stream, bound to the top level.
// Depends on stk_pkg and stk500v2_message_deframer.
`default_nettype none

module stk_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // tlast marks exactly the frame-complete and bad-header results
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != stk_pkg::KIND_BODY)))
        else $error("tlast does not match kind");

    // only body bytes carry data
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != stk_pkg::KIND_BODY |-> m_axis_tdata[7:0] == 8'h00)
        else $error("nonzero data on a closing result");

    // no result reaches the output right after reset
    a_no_early: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result right after reset");

    // with no result offered and no byte offered at the last sample, the input is ready
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled with nothing pending");

endmodule

bind stk500v2_message_deframer stk_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
